// ===== hdl/rrbb_pkg.sv =====
`timescale 1ns / 1ps
package rrbb_pkg;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int DEFAULT_SIZE   = 32;

  localparam int POS_W   = 24;
  localparam int TEX_W   = 11;
  localparam int SCALE_W = 12;
  localparam int ROT_W   = 13;
  localparam int BOXP_W  = 26;
  localparam int BOXS_W  = 24;
  localparam int SIZE_W  = TEX_W + SCALE_W;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  localparam int ROMV_W  = TRIG_FRAC_BITS + 1;

  localparam logic [ROT_W-1:0] ANGLE_TURN    = ROT_W'(5760);
  localparam logic [ROT_W-1:0] ANGLE_QUARTER = ROT_W'(1440);
  localparam int               QUARTER       = 1440;
  localparam logic [SIZE_W-1:0] DEF_SIZE_Q8  = SIZE_W'(DEFAULT_SIZE * 256);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic [ROMV_W-1:0] sin_rom_t [0:QUARTER];

  function automatic sin_rom_t build_sin_rom();
    sin_rom_t    rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      q;
    longint      one;
    for (int r = 0; r <= QUARTER; r++) begin
      x    = (64'(r) * 64'd3373259426) / 64'd2880;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      one = longint'(1) << TRIG_FRAC_BITS;
      q   = (sum + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      if (q > one) q = one;
      rom[r] = ROMV_W'(q);
    end
    return rom;
  endfunction

endpackage

// ===== hdl/rrbb_if.sv =====
`timescale 1ns / 1ps
interface rrbb_in_if;
  import rrbb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic                     tex_valid;
  logic [TEX_W-1:0]         tex_width;
  logic [TEX_W-1:0]         tex_height;
  logic [SCALE_W-1:0]       scale_x;
  logic [SCALE_W-1:0]       scale_y;
  logic [ROT_W-1:0]         rotation;
  modport source (output valid, pos_x, pos_y, tex_valid, tex_width, tex_height,
                  scale_x, scale_y, rotation, input ready);
  modport sink   (input valid, pos_x, pos_y, tex_valid, tex_width, tex_height,
                  scale_x, scale_y, rotation, output ready);
endinterface

interface rrbb_out_if;
  import rrbb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [BOXP_W-1:0]  box_x;
  logic signed [BOXP_W-1:0]  box_y;
  logic [BOXS_W-1:0]         box_w;
  logic [BOXS_W-1:0]         box_h;
  modport source (output valid, box_x, box_y, box_w, box_h, input ready);
  modport sink   (input valid, box_x, box_y, box_w, box_h, output ready);
endinterface

// ===== hdl/rotated_rect_bounding_box_unit.sv =====
`timescale 1ns / 1ps
// Bounding box of a rotated, scaled sprite rectangle.
// in_ch: one sprite per transfer (position, texture size, scale, rotation).
// out_ch: one box per sprite, in order (left, top, width, height).
// A sprite taken at an input transfer moves through the stage registers
// (quadrant, table read and centre, products, corners, min / max, output
// register) in order before out_ch.valid rises for its box.
// Throughput: one sprite per cycle while out_ch.ready is high, set by a six-stage
// pipeline, a registered two-port sine/cosine table read, four 24x16 multipliers.
// Each stage holds a valid bit; a stage moves whenever the one after it is
// empty or moving, so bubbles collapse and in_ch.ready stays high while the
// output register is empty.
// When out_ch.ready is low the result holds and stages fill up behind it;
// in_ch.ready drops only once every stage is occupied. Nothing is lost or
// repeated.
// Reset (rst_n low, synchronous) empties all stages; the table is constant
// and needs no fill, so the block is ready in the first cycle after reset.
module rotated_rect_bounding_box_unit (
  input  logic        clk,
  input  logic        rst_n,
  rrbb_in_if.sink     in_ch,
  rrbb_out_if.source  out_ch
);
  import rrbb_pkg::*;

  localparam int CX_W  = POS_W + 3;
  localparam int PR_W  = SIZE_W + 1 + TRIG_W;
  localparam int CR_W  = 29;
  localparam int DF_W  = CR_W + 1;
  localparam sin_rom_t SIN_ROM = build_sin_rom();

  function automatic logic signed [CR_W-1:0] fl_pos(input logic signed [PR_W-1:0] p);
    return CR_W'(p >>> TRIG_FRAC_BITS);
  endfunction

  function automatic logic signed [CR_W-1:0] fl_neg(input logic signed [PR_W-1:0] p);
    logic signed [PR_W-1:0] t;
    t = p + PR_W'((1 << TRIG_FRAC_BITS) - 1);
    return -CR_W'(t >>> TRIG_FRAC_BITS);
  endfunction

  logic en1, en2, en3, en4, en5, en6;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1
  logic [ROT_W-1:0]        ang_nxt;
  logic [1:0]              q_nxt;
  logic [ROT_W-1:0]        rr_nxt;
  logic signed [POS_W-1:0] px1_r, py1_r;
  logic [SIZE_W-1:0]       w1_r, h1_r;
  logic [1:0]              q1_r;
  logic [TEX_W-1:0]        r1_r;
  logic                    z1_r;

  always_comb begin
    ang_nxt = (in_ch.rotation >= ANGLE_TURN) ? in_ch.rotation - ANGLE_TURN : in_ch.rotation;
    if (ang_nxt >= 3 * ANGLE_QUARTER) begin
      q_nxt = QUAD_3; rr_nxt = ang_nxt - ROT_W'(3 * ANGLE_QUARTER);
    end else if (ang_nxt >= 2 * ANGLE_QUARTER) begin
      q_nxt = QUAD_2; rr_nxt = ang_nxt - ROT_W'(2 * ANGLE_QUARTER);
    end else if (ang_nxt >= ANGLE_QUARTER) begin
      q_nxt = QUAD_1; rr_nxt = ang_nxt - ANGLE_QUARTER;
    end else begin
      q_nxt = QUAD_0; rr_nxt = ang_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px1_r <= in_ch.pos_x;
      py1_r <= in_ch.pos_y;
      w1_r  <= in_ch.tex_valid ? SIZE_W'(in_ch.tex_width) * SIZE_W'(in_ch.scale_x)
                               : DEF_SIZE_Q8;
      h1_r  <= in_ch.tex_valid ? SIZE_W'(in_ch.tex_height) * SIZE_W'(in_ch.scale_y)
                               : DEF_SIZE_Q8;
      q1_r  <= q_nxt;
      r1_r  <= TEX_W'(rr_nxt);
      z1_r  <= (ang_nxt == '0);
    end
  end

  // stage 2: table read, centre
  logic [ROMV_W-1:0]       sin2_r, cos2_r;
  logic [TEX_W-1:0]        cidx;
  logic signed [CX_W-1:0]  cx2_r, cy2_r;
  logic signed [POS_W-1:0] px2_r, py2_r;
  logic [SIZE_W-1:0]       w2_r, h2_r;
  logic [1:0]              q2_r;
  logic                    z2_r;

  assign cidx = TEX_W'(ANGLE_QUARTER) - r1_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      sin2_r <= SIN_ROM[r1_r];
      cos2_r <= SIN_ROM[cidx];
      cx2_r  <= (CX_W'(px1_r) <<< 1) + $signed(CX_W'(w1_r));
      cy2_r  <= (CX_W'(py1_r) <<< 1) + $signed(CX_W'(h1_r));
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      w2_r   <= w1_r;
      h2_r   <= h1_r;
      q2_r   <= q1_r;
      z2_r   <= z1_r;
    end
  end

  // stage 3: quadrant signs, products
  logic signed [TRIG_W-1:0] sp, sn, cp, cn, s_nxt, c_nxt;
  logic signed [SIZE_W:0]   ws, hs;
  logic signed [PR_W-1:0]   pwc3_r, phs3_r, pws3_r, phc3_r;
  logic signed [CX_W-1:0]   cx3_r, cy3_r;
  logic signed [POS_W-1:0]  px3_r, py3_r;
  logic [SIZE_W-1:0]        w3_r, h3_r;
  logic                     z3_r;

  always_comb begin
    sp = $signed(TRIG_W'(sin2_r));
    cp = $signed(TRIG_W'(cos2_r));
    sn = -sp;
    cn = -cp;
    ws = $signed({1'b0, w2_r});
    hs = $signed({1'b0, h2_r});
    case (q2_r)
      QUAD_0:  begin s_nxt = sp; c_nxt = cp; end
      QUAD_1:  begin s_nxt = cp; c_nxt = sn; end
      QUAD_2:  begin s_nxt = sn; c_nxt = cn; end
      QUAD_3:  begin s_nxt = cn; c_nxt = sp; end
      default: begin s_nxt = sp; c_nxt = cp; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pwc3_r <= ws * c_nxt;
      phs3_r <= hs * s_nxt;
      pws3_r <= ws * s_nxt;
      phc3_r <= hs * c_nxt;
      cx3_r  <= cx2_r;
      cy3_r  <= cy2_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      w3_r   <= w2_r;
      h3_r   <= h2_r;
      z3_r   <= z2_r;
    end
  end

  // stage 4: corners
  logic signed [CR_W-1:0]  cxe, cye;
  logic signed [CR_W-1:0]  xx4_r [4];
  logic signed [CR_W-1:0]  yy4_r [4];
  logic signed [POS_W-1:0] px4_r, py4_r;
  logic [SIZE_W-1:0]       w4_r, h4_r;
  logic                    z4_r;

  assign cxe = CR_W'(cx3_r);
  assign cye = CR_W'(cy3_r);

  always_ff @(posedge clk) begin
    if (en4) begin
      xx4_r[0] <= cxe + fl_neg(pwc3_r) - fl_neg(phs3_r);
      yy4_r[0] <= cye + fl_neg(pws3_r) + fl_neg(phc3_r);
      xx4_r[1] <= cxe + fl_pos(pwc3_r) - fl_neg(phs3_r);
      yy4_r[1] <= cye + fl_pos(pws3_r) + fl_neg(phc3_r);
      xx4_r[2] <= cxe + fl_pos(pwc3_r) - fl_pos(phs3_r);
      yy4_r[2] <= cye + fl_pos(pws3_r) + fl_pos(phc3_r);
      xx4_r[3] <= cxe + fl_neg(pwc3_r) - fl_pos(phs3_r);
      yy4_r[3] <= cye + fl_neg(pws3_r) + fl_pos(phc3_r);
      px4_r    <= px3_r;
      py4_r    <= py3_r;
      w4_r     <= w3_r;
      h4_r     <= h3_r;
      z4_r     <= z3_r;
    end
  end

  // stage 5: min / max
  logic signed [CR_W-1:0]  mnx_nxt, mxx_nxt, mny_nxt, mxy_nxt;
  logic signed [CR_W-1:0]  mnx5_r, mxx5_r, mny5_r, mxy5_r;
  logic signed [POS_W-1:0] px5_r, py5_r;
  logic [SIZE_W-1:0]       w5_r, h5_r;
  logic                    z5_r;

  always_comb begin
    mnx_nxt = xx4_r[0]; mxx_nxt = xx4_r[0];
    mny_nxt = yy4_r[0]; mxy_nxt = yy4_r[0];
    for (int i = 1; i < 4; i++) begin
      if (xx4_r[i] < mnx_nxt) mnx_nxt = xx4_r[i];
      if (xx4_r[i] > mxx_nxt) mxx_nxt = xx4_r[i];
      if (yy4_r[i] < mny_nxt) mny_nxt = yy4_r[i];
      if (yy4_r[i] > mxy_nxt) mxy_nxt = yy4_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      mnx5_r <= mnx_nxt;
      mxx5_r <= mxx_nxt;
      mny5_r <= mny_nxt;
      mxy5_r <= mxy_nxt;
      px5_r  <= px4_r;
      py5_r  <= py4_r;
      w5_r   <= w4_r;
      h5_r   <= h4_r;
      z5_r   <= z4_r;
    end
  end

  // stage 6: halve, saturate, output register
  logic signed [CR_W-1:0]   hx, hy;
  logic signed [DF_W-1:0]   dx, dy;
  logic signed [BOXP_W-1:0] bx_nxt, by_nxt;
  logic [BOXS_W-1:0]        bw_nxt, bh_nxt;
  logic signed [BOXP_W-1:0] bx_r, by_r;
  logic [BOXS_W-1:0]        bw_r, bh_r;

  localparam logic signed [CR_W-1:0] PMAX = CR_W'((1 << (BOXP_W - 1)) - 1);
  localparam logic signed [CR_W-1:0] PMIN = -CR_W'(1 << (BOXP_W - 1));
  localparam logic signed [DF_W-1:0] SMAX = DF_W'((1 << BOXS_W) - 1);

  always_comb begin
    hx = mnx5_r >>> 1;
    hy = mny5_r >>> 1;
    dx = (DF_W'(mxx5_r) - DF_W'(mnx5_r)) >>> 1;
    dy = (DF_W'(mxy5_r) - DF_W'(mny5_r)) >>> 1;
    bx_nxt = (hx > PMAX) ? BOXP_W'(PMAX) : (hx < PMIN) ? BOXP_W'(PMIN) : BOXP_W'(hx);
    by_nxt = (hy > PMAX) ? BOXP_W'(PMAX) : (hy < PMIN) ? BOXP_W'(PMIN) : BOXP_W'(hy);
    bw_nxt = (dx > SMAX) ? BOXS_W'(SMAX) : (dx < 0) ? '0 : BOXS_W'(dx);
    bh_nxt = (dy > SMAX) ? BOXS_W'(SMAX) : (dy < 0) ? '0 : BOXS_W'(dy);
    if (z5_r) begin
      bx_nxt = BOXP_W'(px5_r);
      by_nxt = BOXP_W'(py5_r);
      bw_nxt = BOXS_W'(w5_r);
      bh_nxt = BOXS_W'(h5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      bx_r <= bx_nxt;
      by_r <= by_nxt;
      bw_r <= bw_nxt;
      bh_r <= bh_nxt;
    end
  end

  // handshake and valid bits
  assign en6 = !v6_r || out_ch.ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  assign in_ch.ready  = en1;
  assign out_ch.valid = v6_r;
  assign out_ch.box_x = bx_r;
  assign out_ch.box_y = by_r;
  assign out_ch.box_w = bw_r;
  assign out_ch.box_h = bh_r;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !v4_r && !v5_r && !v6_r)
    else $error("pipeline not empty after reset");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

  a_unrotated_size: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && en6 && z5_r |=> out_ch.box_w == BOXS_W'($past(w5_r))
                            && out_ch.box_x == BOXP_W'($past(px5_r)))
    else $error("unrotated box differs from position and size");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !en5 |=> v5_r && $stable(mnx5_r) && $stable(mxx5_r))
    else $error("stalled stage lost its data");

endmodule

// ===== tb/rrbb_tb_if.sv =====
`timescale 1ns / 1ps
package rrbb_tb_pkg;
  import rrbb_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    tex_valid;
    logic [TEX_W-1:0]        tex_width;
    logic [TEX_W-1:0]        tex_height;
    logic [SCALE_W-1:0]      scale_x;
    logic [SCALE_W-1:0]      scale_y;
    logic [ROT_W-1:0]        rotation;
  } sprite_t;

  typedef struct packed {
    logic signed [BOXP_W-1:0] box_x;
    logic signed [BOXP_W-1:0] box_y;
    logic [BOXS_W-1:0]        box_w;
    logic [BOXS_W-1:0]        box_h;
  } box_t;
endpackage

// ===== tb/rotated_rect_bounding_box_unit_tb.sv =====
`timescale 1ns / 1ps
module rotated_rect_bounding_box_unit_tb;
  import rrbb_pkg::*;
  import rrbb_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rrbb_in_if  in_ch ();
  rrbb_out_if out_ch ();

  rotated_rect_bounding_box_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sprite_t pending_sprites[$];
  box_t    expected_boxes[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_cycles = 0;
  int      mismatches = 0;
  bit      stim_done = 1'b0;
  bit      in_fire = 1'b0;
  longint  sin_q30_table[0:1440];

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint quarter_sine(int r);
    longint unsigned x, x2, term;
    longint sum, q;
    x = (longint'(r) * 64'd3373259426) / 64'd2880;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    sum = sat(sum, 0, 64'sd1073741824);
    q = (sum + (64'sd1 << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    return q > (64'sd1 << TRIG_FRAC_BITS) ? (64'sd1 << TRIG_FRAC_BITS) : q;
  endfunction

  function automatic box_t bound_rotated_sprite(sprite_t sp);
    box_t bx;
    longint px, py, w, h, rx, ry, rw, rh, sr, cr, s, c, cx, cy, a, b, xx, yy;
    longint minx, maxx, miny, maxy;
    int ang, quad, r;
    px = longint'(sp.pos_x);
    py = longint'(sp.pos_y);
    ang = int'(sp.rotation) % 5760;
    if (sp.tex_valid) begin
      w = longint'(sp.tex_width) * longint'(sp.scale_x);
      h = longint'(sp.tex_height) * longint'(sp.scale_y);
    end else begin
      w = DEFAULT_SIZE * 256;
      h = DEFAULT_SIZE * 256;
    end
    if (ang == 0) begin
      rx = px; ry = py; rw = w; rh = h;
    end else begin
      quad = ang / 1440;
      r = ang % 1440;
      sr = sin_q30_table[r];
      cr = sin_q30_table[1440 - r];
      case (quad)
        0: begin s = sr; c = cr; end
        1: begin s = cr; c = -sr; end
        2: begin s = -sr; c = -cr; end
        default: begin s = -cr; c = sr; end
      endcase
      cx = px * 2 + w;
      cy = py * 2 + h;
      for (int i = 0; i < 4; i++) begin
        a = (i == 0 || i == 3) ? -w : w;
        b = (i < 2) ? -h : h;
        xx = cx + floor_div(a * c, TRIG_FRAC_BITS) - floor_div(b * s, TRIG_FRAC_BITS);
        yy = cy + floor_div(a * s, TRIG_FRAC_BITS) + floor_div(b * c, TRIG_FRAC_BITS);
        if (i == 0 || xx < minx) minx = xx;
        if (i == 0 || xx > maxx) maxx = xx;
        if (i == 0 || yy < miny) miny = yy;
        if (i == 0 || yy > maxy) maxy = yy;
      end
      rx = floor_div(minx, 1);
      ry = floor_div(miny, 1);
      rw = floor_div(maxx - minx, 1);
      rh = floor_div(maxy - miny, 1);
    end
    bx.box_x = BOXP_W'(sat(rx, -33554432, 33554431));
    bx.box_y = BOXP_W'(sat(ry, -33554432, 33554431));
    bx.box_w = BOXS_W'(sat(rw, 0, 16777215));
    bx.box_h = BOXS_W'(sat(rh, 0, 16777215));
    return bx;
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t sp;
    sp.pos_x = POS_W'($urandom);
    sp.pos_y = POS_W'($urandom);
    sp.tex_valid = ($urandom_range(0, 9) != 0);
    sp.tex_width = ($urandom_range(0, 3) == 0) ? TEX_W'($urandom) : TEX_W'($urandom_range(0, 128));
    sp.tex_height = ($urandom_range(0, 3) == 0) ? TEX_W'($urandom) : TEX_W'($urandom_range(0, 128));
    sp.scale_x = SCALE_W'($urandom);
    sp.scale_y = SCALE_W'($urandom);
    case ($urandom_range(0, 7))
      0: sp.rotation = '0;
      1: sp.rotation = ROT_W'(1440 * $urandom_range(0, 5));
      2: sp.rotation = ROT_W'($urandom_range(5760, 8191));
      default: sp.rotation = ROT_W'($urandom_range(0, 5759));
    endcase
    return sp;
  endfunction

  task automatic queue_sprite(input int x, y, input logic tv,
                              input int tw, th, sx, sy, rot);
    sprite_t sp;
    sp.pos_x = POS_W'(x); sp.pos_y = POS_W'(y); sp.tex_valid = tv;
    sp.tex_width = TEX_W'(tw); sp.tex_height = TEX_W'(th);
    sp.scale_x = SCALE_W'(sx); sp.scale_y = SCALE_W'(sy);
    sp.rotation = ROT_W'(rot);
    pending_sprites.push_back(sp);
  endtask

  // record the input transfer at the rising edge
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        expected_boxes.push_back(bound_rotated_sprite(pending_sprites.pop_front()));
      end
      if (pending_sprites.size() != 0 &&
          (in_ch.valid && !in_fire || $urandom_range(0, 99) >= send_idle_pct)) begin
        in_ch.valid <= 1'b1;
        {in_ch.pos_x, in_ch.pos_y, in_ch.tex_valid, in_ch.tex_width, in_ch.tex_height,
         in_ch.scale_x, in_ch.scale_y, in_ch.rotation} <= pending_sprites[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: hold off for a counted stretch, else stall at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    box_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected box transfer %p", out_ch.box_x);
      end else begin
        want = expected_boxes.pop_front();
        if (want.box_x !== out_ch.box_x || want.box_y !== out_ch.box_y ||
            want.box_w !== out_ch.box_w || want.box_h !== out_ch.box_h) begin
          mismatches++;
          if (mismatches <= 10)
            $display("box mismatch: exp x=%0d y=%0d w=%0d h=%0d got x=%0d y=%0d w=%0d h=%0d",
                     want.box_x, want.box_y, want.box_w, want.box_h,
                     out_ch.box_x, out_ch.box_y, out_ch.box_w, out_ch.box_h);
        end
      end
    end
  end

  task automatic run_phase(input int n, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) pending_sprites.push_back(random_sprite());
    while (pending_sprites.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.tex_valid = 1'b0;
    in_ch.tex_width = '0; in_ch.tex_height = '0;
    in_ch.scale_x = '0; in_ch.scale_y = '0; in_ch.rotation = '0;
    out_ch.ready = 1'b0;
    for (int r = 0; r <= 1440; r++) sin_q30_table[r] = quarter_sine(r);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    queue_sprite(8388607, -8388608, 1'b1, 2047, 2047, 4095, 4095, 0);
    queue_sprite(-8388608, 8388607, 1'b1, 2047, 2047, 4095, 4095, 720);
    queue_sprite(8388607, 8388607, 1'b1, 2047, 2047, 4095, 4095, 2880);
    queue_sprite(-8388608, -8388608, 1'b1, 2047, 1, 4095, 256, 4000);
    queue_sprite(0, 0, 1'b0, 2047, 2047, 4095, 4095, 0);
    queue_sprite(256, -256, 1'b0, 0, 0, 0, 0, 1);
    queue_sprite(100, 200, 1'b1, 0, 10, 256, 256, 300);
    queue_sprite(100, 200, 1'b1, 10, 10, 0, 0, 300);
    queue_sprite(0, 0, 1'b1, 64, 32, 256, 512, 1440);
    queue_sprite(0, 0, 1'b1, 64, 32, 256, 512, 2880);
    queue_sprite(0, 0, 1'b1, 64, 32, 256, 512, 4320);
    queue_sprite(0, 0, 1'b1, 64, 32, 256, 512, 5759);
    queue_sprite(0, 0, 1'b1, 64, 32, 256, 512, 5760);
    queue_sprite(0, 0, 1'b1, 64, 32, 256, 512, 8191);
    queue_sprite(-5000, 7000, 1'b1, 1024, 3, 2048, 17, 7200);
    queue_sprite(1234, -4321, 1'b1, 1365, 682, 2730, 1365, 1439);
    queue_sprite(-1, -1, 1'b1, 1, 1, 1, 1, 1441);
    run_phase(350, 0, 0);
    run_phase(350, 87, 0);
    run_phase(350, 0, 87);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 200;
    run_phase(150, 0, 0);
    run_phase(350, 36, 36);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (expected_boxes.size() != 0 || in_ch.valid) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/rrbb_pkg.sv
hdl/rrbb_if.sv
hdl/rotated_rect_bounding_box_unit.sv
tb/rrbb_tb_if.sv
tb/rotated_rect_bounding_box_unit_tb.sv
